@@ sv/fir_pkg.sv @@
// Shared types and constants for the streaming FIR filter.
package fir_pkg;

  // Filter length and field widths.
  localparam int TAP_COUNT = 41;
  localparam int SAMPLE_W  = 16;
  localparam int IDX_W     = 6;
  localparam int PROD_W    = 2 * SAMPLE_W;
  // Worst-case product magnitude is 2^30, so log2 of the tap count extra bits suffice.
  localparam int ACC_W     = PROD_W + $clog2(TAP_COUNT);
  // Width that holds any tap number and any tap index word without aliasing.
  localparam int SEL_W     = ($clog2(TAP_COUNT + 1) > IDX_W) ? $clog2(TAP_COUNT + 1) : IDX_W;

  // Rounding from Q8.30 to Q1.15.
  localparam int FRAC_SHIFT = SAMPLE_W - 1;
  localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
  localparam int RQ_W       = ACC_W + 1 - FRAC_SHIFT;
  localparam int SAT_MAX    = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAT_MIN    = -(1 << (SAMPLE_W - 1));

  typedef enum logic [0:0] {
    ACT_PUSH = 1'b0,
    ACT_LOAD = 1'b1
  } action_t;

  typedef struct packed {
    action_t                     action;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [IDX_W-1:0]     tap_index;
    logic signed [SAMPLE_W-1:0]  tap_value;
  } req_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  filtered;
    logic                        clipped;
  } rsp_word_t;

  // Data that one cell hands to the next: delayed sample, the sum token and the running sum.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        tok;
    logic signed [ACC_W-1:0]     acc;
  } tap_link_t;

  // Control that the top level drives into each cell.
  typedef struct packed {
    logic                        shift;
    logic                        load;
    logic signed [SAMPLE_W-1:0]  tap_value;
  } cell_ctrl_t;

endpackage

@@ sv/fir_cell.sv @@
// One tap cell: delay stage, coefficient, product register and a slice of the sum chain.
module fir_cell (
  input  logic               clk,
  input  logic               rst,
  input  fir_pkg::cell_ctrl_t ctrl,
  input  fir_pkg::tap_link_t link_in,
  output fir_pkg::tap_link_t link_out
);

  logic signed [fir_pkg::SAMPLE_W-1:0] sample;
  logic signed [fir_pkg::SAMPLE_W-1:0] coef;
  logic signed [fir_pkg::PROD_W-1:0]   prod;
  logic                                tok;
  logic signed [fir_pkg::ACC_W-1:0]    acc;

  // Delay stage, coefficient and token carry reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
      coef   <= '0;
      tok    <= 1'b0;
    end else begin
      if (ctrl.shift) begin
        sample <= link_in.sample;
      end
      if (ctrl.load) begin
        coef <= ctrl.tap_value;
      end
      tok <= link_in.tok;
    end
  end

  // The product is registered every cycle; the sum advances when the token passes.
  always_ff @(posedge clk) begin
    prod <= coef * sample;
    if (link_in.tok) begin
      acc <= link_in.acc + fir_pkg::ACC_W'(prod);
    end
  end

  assign link_out.sample = sample;
  assign link_out.tok    = tok;
  assign link_out.acc    = acc;

endmodule

@@ sv/fir_out_stage.sv @@
// Rounding, saturation and the output register with a one-word holding slot.
module fir_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  fir_pkg::tap_link_t  fin_link,
  input  logic                rsp_stall,
  output logic                rsp_valid,
  output fir_pkg::rsp_word_t  rsp_word,
  output logic                hold_busy
);

  logic signed [fir_pkg::ACC_W:0]      rsum;
  logic signed [fir_pkg::RQ_W-1:0]     rq;
  fir_pkg::rsp_word_t                  result;
  fir_pkg::rsp_word_t                  hold_word;
  logic                                hold_valid;
  logic                                out_free;

  // Add half an LSB and drop the fraction bits (floor), then clamp to 16 bits.
  always_comb begin
    rsum = (fir_pkg::ACC_W + 1)'(fin_link.acc) + (fir_pkg::ACC_W + 1)'(fir_pkg::ROUND_BIAS);
    rq   = rsum[fir_pkg::ACC_W:fir_pkg::FRAC_SHIFT];
    if (rq > fir_pkg::RQ_W'(fir_pkg::SAT_MAX)) begin
      result.filtered = fir_pkg::SAMPLE_W'(fir_pkg::SAT_MAX);
      result.clipped  = 1'b1;
    end else if (rq < fir_pkg::RQ_W'(fir_pkg::SAT_MIN)) begin
      result.filtered = fir_pkg::SAMPLE_W'(fir_pkg::SAT_MIN);
      result.clipped  = 1'b1;
    end else begin
      result.filtered = rq[fir_pkg::SAMPLE_W-1:0];
      result.clipped  = 1'b0;
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;

  // Output register; a result that finds it stalled waits in the holding slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (hold_valid) begin
          rsp_valid  <= 1'b1;
          hold_valid <= 1'b0;
        end else begin
          rsp_valid <= fin_link.tok;
        end
      end else if (fin_link.tok) begin
        hold_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) begin
        rsp_word <= hold_word;
      end else if (fin_link.tok) begin
        rsp_word <= result;
      end
    end else if (fin_link.tok) begin
      hold_word <= result;
    end
  end

  assign hold_busy = hold_valid;

endmodule

@@ sv/fir_filter_stream.sv @@
// Top level of the streaming FIR filter: a chain of tap cells and the output stage.
//
//   channel  | handshake              | word
//   ---------+------------------------+---------------------------------------------
//   request  | req_valid / req_stall  | req_word: action, sample, tap_index, tap_value
//   result   | rsp_valid / rsp_stall  | rsp_word: filtered, clipped
//
// A sample push first shifts the delay line and then registers the products (go1, go2);
// the running sum then travels through the tap cells one cell per cycle.
// Reset clears the delay line, the coefficients and all handshake state.
// req_stall is high while a sum runs or a finished word waits in the holding slot;
// a stalled result side leaves one word in the output register and one in the slot.
module fir_filter_stream (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  fir_pkg::req_word_t req_word,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output fir_pkg::rsp_word_t rsp_word
);

  fir_pkg::tap_link_t  links [0:fir_pkg::TAP_COUNT];
  fir_pkg::cell_ctrl_t ctrl  [0:fir_pkg::TAP_COUNT-1];
  logic                accept;
  logic                push_acc;
  logic                load_acc;
  logic                running;
  logic                go1;
  logic                go2;
  logic                hold_busy;

  assign req_stall = running || hold_busy;
  assign accept    = req_valid && !req_stall;
  assign push_acc  = accept && (req_word.action == fir_pkg::ACT_PUSH);
  assign load_acc  = accept && (req_word.action == fir_pkg::ACT_LOAD);

  // Sequencing: a push passes through go1 and go2 before the sum starts, once the products are fresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      go1     <= 1'b0;
      go2     <= 1'b0;
    end else begin
      go1 <= push_acc;
      go2 <= go1;
      if (push_acc) begin
        running <= 1'b1;
      end else if (links[fir_pkg::TAP_COUNT].tok) begin
        running <= 1'b0;
      end
    end
  end

  // Head of the chain: the new sample and an empty sum.
  assign links[0].sample = req_word.sample;
  assign links[0].tok    = go2;
  assign links[0].acc    = '0;

  // The row of tap cells; tap 0 holds the newest sample.
  for (genvar k = 0; k < fir_pkg::TAP_COUNT; k++) begin : g_tap
    assign ctrl[k].shift     = push_acc;
    assign ctrl[k].load      = load_acc &&
        (fir_pkg::SEL_W'(req_word.tap_index) == fir_pkg::SEL_W'(k));
    assign ctrl[k].tap_value = req_word.tap_value;

    fir_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[k]),
      .link_in  (links[k]),
      .link_out (links[k+1])
    );
  end

  // Rounding, saturation and the result register.
  fir_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fin_link  (links[fir_pkg::TAP_COUNT]),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_word  (rsp_word),
    .hold_busy (hold_busy)
  );

endmodule
